### hw/rtl/ldcw_pkg.sv
package ldcw_pkg;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned REG_W    = 32;
  localparam int unsigned FORCE_W  = 48;
  localparam int unsigned PROB_W   = 16;

  // square root: 38-bit radicand, 19-bit root (distance in Q16.16, below 5.0)
  localparam int unsigned SQ_IN_W = 38;
  localparam int unsigned DIST_W  = 19;
  // clamped |z|, at most 16.0 in Q16.16
  localparam int unsigned ABS_W   = 21;
  localparam int unsigned T_W     = 21;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned M_W     = 33;
  localparam int unsigned DEN_W   = 34;
  localparam int unsigned QUO_W   = 18;
  localparam int unsigned EXP_STEPS = 16;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  localparam int unsigned SQRT_LAT = DIST_W;
  // exponent product, exp steps, shift, divider, rounding
  localparam int unsigned LOGI_LAT = 1 + EXP_STEPS + 1 + QUO_W + 1;

  typedef struct packed {
    logic [COORD_W-1:0]  src_x;
    logic [COORD_W-1:0]  src_y;
    logic [COORD_W-1:0]  dst_x;
    logic [COORD_W-1:0]  dst_y;
    logic [WEIGHT_W-1:0] infect_weight;
    logic                row_last;
  } in_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_res;
    logic [PROB_W-1:0]         live_prob;
    logic [PROB_W-1:0]         carcass_prob;
    logic                      saturated;
    logic                      last;
  } out_t;

  typedef enum logic [2:0] {
    REG_LIVE_ICPT  = 3'd0,
    REG_LIVE_SLOPE = 3'd1,
    REG_CARC_ICPT  = 3'd2,
    REG_CARC_SLOPE = 3'd3,
    REG_LIVE_GAIN  = 3'd4,
    REG_CARC_GAIN  = 3'd5
  } cfg_reg_e;

  // c0 = 0.5, ck = sqrt(c(k-1)) in Q0.32, ~2^(-2^-k)
  function automatic logic [31:0] root_coef(input int k);
    logic [31:0] c;
    logic [63:0] n;
    logic [31:0] r;
    logic [31:0] cand;
    c = 32'h8000_0000;
    for (int j = 1; j <= k; j++) begin
      n = {c, 32'h0};
      r = '0;
      for (int b = 31; b >= 0; b--) begin
        cand = r | (32'd1 << b);
        if ({32'h0, cand} * {32'h0, cand} <= n) r = cand;
      end
      c = r;
    end
    return c;
  endfunction

endpackage

### hw/rtl/distance_logistic_contact_weight_core.sv
// Logistic distance-decay contact weight. One (source, target) pair per clock
// enters on the input word while in_ready_o is high; result words leave in order.
// The latency is set by the 19-stage square root for the distance and, in each
// of the two logistic units, the 16-step exponent product chain and the 18-stage
// reciprocal divider. A two-entry output (register plus skid) keeps input ready
// high while one finished word waits; ready drops only when both are full.
// Pairs at zero distance or 5 units or more give zero force and probabilities.
// Registers are to be written only while the pipeline is empty; the core itself does not enforce this.
module distance_logistic_contact_weight_core import ldcw_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_word_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned ABW   = COORD_FRAC_BITS + 3;
  localparam int unsigned SQW   = 2 * ABW + 1;
  localparam int unsigned SHAMT = 32 - 2 * COORD_FRAC_BITS;
  localparam logic [COORD_W:0] LIM    = (COORD_W+1)'(5) << COORD_FRAC_BITS;
  localparam logic [SQW-1:0]   D2_LIM = SQW'(25) << (2 * COORD_FRAC_BITS);

  localparam int unsigned IDX_B    = 1;
  localparam int unsigned IDX_DIST = IDX_B + SQRT_LAT;
  localparam int unsigned IDX_C    = IDX_DIST + 1;
  localparam int unsigned IDX_D    = IDX_C + 1;
  localparam int unsigned IDX_P    = IDX_D + LOGI_LAT;
  localparam int unsigned IDX_E    = IDX_P + 1;
  localparam int unsigned IDX_F    = IDX_E + 1;
  localparam int unsigned DEPTH    = IDX_F + 1;

  localparam logic signed [49:0] F_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] F_MIN = -50'sh0_8000_0000_0000;

  typedef struct packed {
    logic                inr;
    logic                last;
    logic [WEIGHT_W-1:0] w;
  } sb_t;

  // config registers
  logic signed [REG_W-1:0] live_icpt_q, live_slope_q, carc_icpt_q, carc_slope_q;
  logic signed [REG_W-1:0] live_gain_q, carc_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_icpt_q  <= '0;
      live_slope_q <= '0;
      carc_icpt_q  <= '0;
      carc_slope_q <= '0;
      live_gain_q  <= 32'sd65536;
      carc_gain_q  <= 32'sd65536;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LIVE_ICPT:  live_icpt_q  <= cfg_data_i;
        REG_LIVE_SLOPE: live_slope_q <= cfg_data_i;
        REG_CARC_ICPT:  carc_icpt_q  <= cfg_data_i;
        REG_CARC_SLOPE: carc_slope_q <= cfg_data_i;
        REG_LIVE_GAIN:  live_gain_q  <= cfg_data_i;
        REG_CARC_GAIN:  carc_gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advances as a whole while the skid slot is free
  logic en;
  logic skid_v_q, out_v_q;
  out_t out_q, skid_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  logic [DEPTH-1:0] v_q;
  sb_t              sb_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[DEPTH-2:0], in_valid_i};
    end
  end

  // stage A: coordinate deltas
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]        adx, ady;
  logic [ABW-1:0]          adx_q, ady_q;
  logic                    small_q;

  assign dx  = $signed({1'b0, in_word_i.dst_x}) - $signed({1'b0, in_word_i.src_x});
  assign dy  = $signed({1'b0, in_word_i.dst_y}) - $signed({1'b0, in_word_i.src_y});
  assign adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
  assign ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;

  // stage B: squared distance and range test
  logic [SQW-1:0]     sq;
  logic               inr;
  logic [SQ_IN_W-1:0] arg_q;

  assign sq  = SQW'(adx_q * adx_q) + SQW'(ady_q * ady_q);
  assign inr = small_q && (sq != '0) && (sq < D2_LIM);

  always_ff @(posedge clk_i) begin
    if (en) begin
      adx_q   <= adx[ABW-1:0];
      ady_q   <= ady[ABW-1:0];
      small_q <= (adx < LIM) && (ady < LIM);
      sb_q[0] <= '{inr: 1'b0, last: in_word_i.row_last, w: in_word_i.infect_weight};
      sb_q[1] <= '{inr: inr, last: sb_q[0].last, w: sb_q[0].w};
      for (int j = 2; j < DEPTH; j++) sb_q[j] <= sb_q[j-1];
      arg_q   <= SQ_IN_W'(sq) << SHAMT;
    end
  end

  logic [DIST_W-1:0] dist_val;

  ldcw_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .arg_i  (arg_q),
    .root_o (dist_val)
  );

  // stage C: slope * distance
  logic signed [51:0] prodl_q, prodc_q;

  // stage D: z, clamp to +-16.0, magnitude and sign
  function automatic logic [ABS_W:0] clamp_abs(input logic signed [35:0] z);
    logic [ABS_W-1:0] a;
    if (z > 36'sd1048576 || z < -36'sd1048576) a = ABS_W'(21'h100000);
    else if (z < 0) a = ABS_W'(-z);
    else a = ABS_W'(z);
    return {z[35], a};
  endfunction

  logic signed [35:0] zl, zc;
  logic [ABS_W:0]     azl, azc;
  logic [ABS_W-1:0]   al_q, ac_q;
  logic               negl_q, negc_q;

  assign zl  = 36'(live_icpt_q) + $signed(prodl_q[51:16]);
  assign zc  = 36'(carc_icpt_q) + $signed(prodc_q[51:16]);
  assign azl = clamp_abs(zl);
  assign azc = clamp_abs(zc);

  always_ff @(posedge clk_i) begin
    if (en) begin
      prodl_q <= live_slope_q * $signed({1'b0, dist_val});
      prodc_q <= carc_slope_q * $signed({1'b0, dist_val});
      negl_q  <= azl[ABS_W];
      al_q    <= azl[ABS_W-1:0];
      negc_q  <= azc[ABS_W];
      ac_q    <= azc[ABS_W-1:0];
    end
  end

  logic [PROB_W-1:0] pl, pc;

  ldcw_logistic u_live (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (al_q),
    .neg_i (negl_q),
    .p_o   (pl)
  );

  ldcw_logistic u_carc (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (ac_q),
    .neg_i (negc_q),
    .p_o   (pc)
  );

  // stage E: p * w; stage F: gain * (p * w) >>> 16
  logic [31:0]          pwl_q, pwc_q;
  logic [PROB_W-1:0]    pl_e_q, pc_e_q, pl_f_q, pc_f_q;
  logic signed [64:0]   terml, termc;
  logic signed [48:0]   tl_q, tc_q;

  assign terml = live_gain_q * $signed({1'b0, pwl_q});
  assign termc = carc_gain_q * $signed({1'b0, pwc_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      pwl_q  <= pl * sb_q[IDX_P].w;
      pwc_q  <= pc * sb_q[IDX_P].w;
      pl_e_q <= pl;
      pc_e_q <= pc;
      tl_q   <= terml[64:16];
      tc_q   <= termc[64:16];
      pl_f_q <= pl_e_q;
      pc_f_q <= pc_e_q;
    end
  end

  // sum, clip, zero out-of-range pairs
  logic signed [49:0] fsum;
  out_t               res;

  assign fsum = 50'(tl_q) + 50'(tc_q);

  always_comb begin
    res.last         = sb_q[IDX_F].last;
    res.live_prob    = pl_f_q;
    res.carcass_prob = pc_f_q;
    res.saturated    = 1'b0;
    res.force_res    = fsum[FORCE_W-1:0];
    if (fsum > F_MAX) begin
      res.force_res = F_MAX[FORCE_W-1:0];
      res.saturated = 1'b1;
    end else if (fsum < F_MIN) begin
      res.force_res = F_MIN[FORCE_W-1:0];
      res.saturated = 1'b1;
    end
    if (!sb_q[IDX_F].inr) begin
      res.force_res    = '0;
      res.live_prob    = '0;
      res.carcass_prob = '0;
      res.saturated    = 1'b0;
    end
  end

  // output word register plus skid slot
  logic push;
  assign push = en && v_q[IDX_F];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (skid_v_q) begin
        if (out_ready_i) skid_v_q <= 1'b0;
      end else if (push) begin
        if (out_v_q && !out_ready_i) skid_v_q <= 1'b1;
        else out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_ready_i) out_q <= skid_q;
    end else if (push) begin
      if (out_v_q && !out_ready_i) skid_q <= res;
      else out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid slot full while output register empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid slot filled without a stalled output word");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.saturated) |->
      (out_q.force_res == F_MAX[FORCE_W-1:0] || out_q.force_res == F_MIN[FORCE_W-1:0]))
    else $error("saturated word without clipped force");

endmodule

### hw/rtl/ldcw_isqrt.sv
module ldcw_isqrt import ldcw_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SQ_IN_W-1:0] arg_i,
  output logic [DIST_W-1:0]  root_o
);

  localparam int unsigned REM_W = DIST_W + 3;

  logic [REM_W-1:0]   rem_q  [DIST_W];
  logic [DIST_W-1:0]  root_q [DIST_W];
  logic [SQ_IN_W-1:0] rest_q [DIST_W];

  // one root bit per stage, two radicand bits shifted in
  for (genvar j = 0; j < DIST_W; j++) begin : g_stage
    logic [REM_W-1:0]   rem_in;
    logic [DIST_W-1:0]  root_in;
    logic [SQ_IN_W-1:0] rest_in;
    logic [REM_W-1:0]   r2;
    logic [REM_W-1:0]   trial;
    logic               ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = arg_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rest_in = rest_q[j-1];
    end

    assign r2    = {rem_in[REM_W-3:0], rest_in[SQ_IN_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? (r2 - trial) : r2;
        root_q[j] <= {root_in[DIST_W-2:0], ge};
        rest_q[j] <= rest_in << 2;
      end
    end
  end

  assign root_o = root_q[DIST_W-1];

endmodule

### hw/rtl/ldcw_logistic.sv
module ldcw_logistic import ldcw_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [ABS_W-1:0]  a_i,
  input  logic              neg_i,
  output logic [PROB_W-1:0] p_o
);

  localparam int unsigned REM_W = DEN_W + 1;

  logic [T_W-1:0]      t_q;
  logic [LOGI_LAT-2:0] neg_q;
  logic [51:0]         t_prod;

  assign t_prod = 52'(a_i) * 52'(LOG2E_Q30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q   <= t_prod[30 +: T_W];
      neg_q <= {neg_q[LOGI_LAT-3:0], neg_i};
    end
  end

  // 2^-frac as a product of root coefficients, one per stage
  logic [M_W-1:0]     m_q [EXP_STEPS];
  logic [15:0]        f_q [EXP_STEPS];
  logic [SHIFT_W-1:0] i_q [EXP_STEPS];

  for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_exp
    localparam logic [31:0] CK = root_coef(k);
    logic [M_W-1:0]     m_in;
    logic [15:0]        f_in;
    logic [SHIFT_W-1:0] i_in;
    logic [M_W+31:0]    prod;

    if (k == 1) begin : g_first
      assign m_in = {1'b1, 32'h0};
      assign f_in = t_q[15:0];
      assign i_in = t_q[T_W-1:16];
    end else begin : g_next
      assign m_in = m_q[k-2];
      assign f_in = f_q[k-2];
      assign i_in = i_q[k-2];
    end

    assign prod = m_in * CK;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k-1] <= f_in[16-k] ? prod[M_W+31:32] : m_in;
        f_q[k-1] <= f_in;
        i_q[k-1] <= i_in;
      end
    end
  end

  logic [DEN_W-1:0] den_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= {1'b1, 32'h0} + DEN_W'(m_q[EXP_STEPS-1] >> i_q[EXP_STEPS-1]);
    end
  end

  // 2^49 / den, restoring, one quotient bit per stage
  logic [REM_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DEN_W-1:0] dv_q  [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    logic [REM_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] dv_in;
    logic [REM_W-1:0] r2;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = REM_W'(64'h8000_0000);
      assign quo_in = '0;
      assign dv_in  = den_q;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign dv_in  = dv_q[j-1];
    end

    assign r2 = rem_in << 1;
    assign ge = (r2 >= {1'b0, dv_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? (r2 - {1'b0, dv_in}) : r2;
        quo_q[j] <= {quo_in[QUO_W-2:0], ge};
        dv_q[j]  <= dv_in;
      end
    end
  end

  logic [QUO_W:0]  rnd;
  logic [16:0]     s_pos;
  logic [16:0]     s_sel;
  logic [PROB_W-1:0] p_q;

  assign rnd   = {1'b0, quo_q[QUO_W-1]} + (QUO_W+1)'(1);
  assign s_pos = rnd[17:1];
  assign s_sel = neg_q[LOGI_LAT-2] ? (17'h10000 - s_pos) : s_pos;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= s_sel[16] ? {PROB_W{1'b1}} : s_sel[PROB_W-1:0];
    end
  end

  assign p_o = p_q;

endmodule

### tb/sv/ldcw_checker.sv
module ldcw_checker import ldcw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_word_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  localparam longint FMAX = (64'sd1 <<< 47) - 1;
  localparam longint FMIN = -FMAX - 1;

  logic [31:0] coef_regs [6];
  out_t        expected_words [$];
  logic [63:0] root_tbl [17];

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint fshr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic logic [63:0] sigmoid_q16(input longint z);
    logic [63:0] a, t, f, m, s;
    int unsigned ip;
    if (z > (64'sd16 <<< 16)) z = 64'sd16 <<< 16;
    if (z < -(64'sd16 <<< 16)) z = -(64'sd16 <<< 16);
    a = z < 0 ? -z : z;
    t = (a * 64'd1549082005) >> 30;
    ip = t >> 16;
    f = t & 64'hFFFF;
    m = 64'd1 << 32;
    for (int k = 1; k <= 16; k++)
      if (f[16-k]) m = (m * root_tbl[k]) >> 32;
    m = ip < 64 ? (m >> ip) : 0;
    s = (((64'd1 << 49) / ((64'd1 << 32) + m)) + 1) >> 1;
    if (z < 0) s = 65536 - s;
    if (s > 65535) s = 65535;
    return s;
  endfunction

  function automatic out_t contact_weight(input in_t w);
    out_t r;
    longint dx, dy, dist_val, zl, zc, tl, tc, frc;
    logic [63:0] d2, pl, pc;
    r = '0;
    dx = longint'(w.dst_x) - longint'(w.src_x);
    dy = longint'(w.dst_y) - longint'(w.src_y);
    d2 = dx * dx + dy * dy;
    r.last = w.row_last;
    if (d2 != 0 && d2 < (64'd25 << 16)) begin
      dist_val = isqrt(d2 << 16);
      zl = longint'($signed(coef_regs[REG_LIVE_ICPT]))
         + fshr(longint'($signed(coef_regs[REG_LIVE_SLOPE])) * dist_val, 16);
      zc = longint'($signed(coef_regs[REG_CARC_ICPT]))
         + fshr(longint'($signed(coef_regs[REG_CARC_SLOPE])) * dist_val, 16);
      pl = sigmoid_q16(zl);
      pc = sigmoid_q16(zc);
      tl = fshr(longint'($signed(coef_regs[REG_LIVE_GAIN])) * longint'(pl)
                * longint'(w.infect_weight), 16);
      tc = fshr(longint'($signed(coef_regs[REG_CARC_GAIN])) * longint'(pc)
                * longint'(w.infect_weight), 16);
      frc = tl + tc;
      if (frc > FMAX) begin frc = FMAX; r.saturated = 1; end
      if (frc < FMIN) begin frc = FMIN; r.saturated = 1; end
      r.force_res = frc[47:0];
      r.live_prob = pl[15:0];
      r.carcass_prob = pc[15:0];
    end
    return r;
  endfunction

  initial begin
    root_tbl[0] = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) root_tbl[k] = isqrt(root_tbl[k-1] << 32);
  end

  assign pending_o = expected_words.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_t exp_w;
    if (!rst_ni) begin
      coef_regs[0] <= 0; coef_regs[1] <= 0; coef_regs[2] <= 0; coef_regs[3] <= 0;
      coef_regs[4] <= 32'd65536; coef_regs[5] <= 32'd65536;
      fail_cnt_o <= 0;
      expected_words.delete();
    end else begin
      if (cfg_we_i && cfg_idx_i < 6) coef_regs[cfg_idx_i] <= cfg_data_i;
      if (in_valid_i && in_ready_i) expected_words.push_back(contact_weight(in_word_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %p", $time, out_word_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w !== out_word_i) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_w, out_word_i);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule

### tb/sv/tb_distance_logistic_contact_weight_core.sv
module tb_distance_logistic_contact_weight_core;
  import ldcw_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  in_t  in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  out_t out_word_o;
  logic cfg_we_i = 0;
  logic [2:0] cfg_idx_i = REG_LIVE_ICPT;
  logic [31:0] cfg_data_i = 0;
  int fail_cnt, pending;
  int send_idle_pct, recv_idle_pct;

  distance_logistic_contact_weight_core u_dut (.*);

  ldcw_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_word_i(out_word_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial forever #4 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk_i)
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain_pipe();
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic send_pair(input in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_word_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic in_t near_pair();
    in_t w;
    w.src_x = $urandom;
    w.src_y = $urandom;
    w.dst_x = w.src_x + 24'($signed($urandom_range(1400)) - 700);
    w.dst_y = w.src_y + 24'($signed($urandom_range(1400)) - 700);
    w.infect_weight = $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom);
    w.row_last = $urandom;
    return w;
  endfunction

  function automatic in_t any_pair();
    in_t w;
    w = near_pair();
    if ($urandom_range(4) == 0) begin
      w.dst_x = $urandom; w.dst_y = $urandom;
    end else if ($urandom_range(9) == 0) begin
      w.dst_x = w.src_x; w.dst_y = w.src_y;
    end
    return w;
  endfunction

  task automatic random_coefs();
    logic [31:0] v [6];
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(5))
        0: v[i] = 32'h8000_0000;
        1: v[i] = 32'h7FFF_FFFF;
        2: v[i] = $urandom;
        default: v[i] = 32'($signed($urandom_range(20 << 16)) - (10 << 16));
      endcase
    end
    write_reg(REG_LIVE_ICPT, v[0]);
    write_reg(REG_LIVE_SLOPE, v[1]);
    write_reg(REG_CARC_ICPT, v[2]);
    write_reg(REG_CARC_SLOPE, v[3]);
    write_reg(REG_LIVE_GAIN, v[4]);
    write_reg(REG_CARC_GAIN, v[5]);
  endtask

  initial begin
    in_t w;
    send_idle_pct = 36;
    recv_idle_pct = 70;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    write_reg(REG_LIVE_ICPT, 32'h0001_0000);
    write_reg(REG_LIVE_SLOPE, 32'hFFFF_8000);
    write_reg(REG_CARC_ICPT, 32'hFFFF_0000);
    write_reg(REG_CARC_SLOPE, 32'h0000_4000);
    // directed: zero distance, just inside/at 5 units, extremes of coords
    w = '0; w.infect_weight = 16'hFFFF; send_pair(w);
    w.dst_x = 24'd1; send_pair(w);
    w.dst_x = 24'd1279; send_pair(w);
    w.dst_x = 24'd1280; send_pair(w);
    w.dst_x = 24'd768; w.dst_y = 24'd1024; w.row_last = 1; send_pair(w);
    w = '1; send_pair(w);
    w.src_x = 24'hFFFF00; send_pair(w);
    w = '0; w.src_x = 24'hFFFFFF; send_pair(w);
    w = '1; w.dst_y = 24'hFFFFFE; w.infect_weight = 0; send_pair(w);
    in_valid_i <= 0;
    drain_pipe();
    // saturation both ways at the gain extremes
    write_reg(REG_LIVE_ICPT, 32'h7FFF_FFFF);
    write_reg(REG_CARC_ICPT, 32'h7FFF_FFFF);
    write_reg(REG_LIVE_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_CARC_GAIN, 32'h7FFF_FFFF);
    w = '0; w.dst_x = 24'd300; w.infect_weight = 16'hFFFF; send_pair(w);
    in_valid_i <= 0;
    drain_pipe();
    write_reg(REG_LIVE_ICPT, 32'h7FFF_FFFF);
    write_reg(REG_LIVE_GAIN, 32'h8000_0000);
    write_reg(REG_CARC_GAIN, 32'h8000_0000);
    send_pair(w);
    in_valid_i <= 0;
    drain_pipe();
    write_reg(REG_CARC_SLOPE, 32'h8000_0000);
    write_reg(REG_LIVE_SLOPE, 32'h7FFF_FFFF);
    write_reg(REG_LIVE_ICPT, 32'h0);
    send_pair(w);
    in_valid_i <= 0;
    drain_pipe();
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin send_idle_pct = 70; recv_idle_pct = 36; end
      if (ph == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
      random_coefs();
      for (int n = 0; n < 95; n++) begin
        send_pair($urandom_range(3) == 0 ? any_pair() : near_pair());
        if (n == 40 && ph == 2) begin
          in_valid_i <= 0;
          while (pending != 0) @(posedge clk_i);
        end
      end
      in_valid_i <= 0;
      drain_pipe();
    end
    recv_idle_pct = 0;
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
